// ===== src/fppi_pkg.sv =====
`timescale 1ns / 1ps

package fppi_pkg;

  // fraction bits of the gains and of the internal sums
  localparam int FRAC_BITS = 14;

  localparam int DATA_W   = 16;
  localparam int ERR_W    = DATA_W + 1;
  localparam int GAIN_W   = 15;
  localparam int PROD_W   = GAIN_W + ERR_W;
  localparam int INTEG_W  = 32;
  localparam int ACC_W    = INTEG_W + 1;
  localparam int SUM_W    = 33;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 3;

  // output clamp limits, full scale times 2^FRAC_BITS
  localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(longint'(32767) <<< FRAC_BITS);
  localparam logic signed [SUM_W-1:0] OUT_MIN = SUM_W'(-(longint'(32768) <<< FRAC_BITS));

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KP          = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KI          = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_UPPER = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LOWER = CFG_IDX_W'(3);

  localparam logic signed [INTEG_W-1:0] INTEG_UPPER_RST = 32'sh7FFF_FFFF;
  localparam logic signed [INTEG_W-1:0] INTEG_LOWER_RST = 32'sh8000_0000;

  typedef struct packed {
    logic signed [GAIN_W-1:0]  kp;
    logic signed [GAIN_W-1:0]  ki;
    logic signed [INTEG_W-1:0] integral_upper;
    logic signed [INTEG_W-1:0] integral_lower;
  } cfg_t;

endpackage

// ===== src/fppi_calc.sv =====
`timescale 1ns / 1ps

module fppi_calc (
  input  fppi_pkg::cfg_t            cfg,
  input  logic signed [15:0]        setpoint,
  input  logic signed [15:0]        feedback,
  input  logic signed [31:0]        integral_sum,
  output logic signed [31:0]        integral_next,
  output logic signed [15:0]        drive_next
);
  import fppi_pkg::*;

  logic signed [ERR_W-1:0]   err;
  logic signed [PROD_W-1:0]  p_term;
  logic signed [PROD_W-1:0]  ki_term;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_clamped;
  logic signed [INTEG_W-1:0] i_term;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   sum_clamped;
  logic                      ki_on;

  assign err     = ERR_W'(setpoint) - ERR_W'(feedback);
  assign p_term  = PROD_W'(cfg.kp) * PROD_W'(err);
  assign ki_term = PROD_W'(cfg.ki) * PROD_W'(err);
  assign ki_on   = (cfg.ki != '0);

  // accumulator at full precision, upper bound tested first
  always_comb begin
    acc = ACC_W'(integral_sum) + ACC_W'(ki_term);
    if (acc > ACC_W'(cfg.integral_upper)) begin
      acc_clamped = ACC_W'(cfg.integral_upper);
    end else if (acc < ACC_W'(cfg.integral_lower)) begin
      acc_clamped = ACC_W'(cfg.integral_lower);
    end else begin
      acc_clamped = acc;
    end
  end

  assign integral_next = ki_on ? acc_clamped[INTEG_W-1:0] : integral_sum;
  assign i_term        = ki_on ? acc_clamped[INTEG_W-1:0] : '0;

  always_comb begin
    sum = SUM_W'(p_term) + SUM_W'(i_term);
    if (sum > OUT_MAX) begin
      sum_clamped = OUT_MAX;
    end else if (sum < OUT_MIN) begin
      sum_clamped = OUT_MIN;
    end else begin
      sum_clamped = sum;
    end
  end

  // floor shift plus round half up; limits have the round bit clear
  assign drive_next = sum_clamped[FRAC_BITS+DATA_W-1:FRAC_BITS]
                    + DATA_W'(sum_clamped[FRAC_BITS-1]);

endmodule

// ===== src/fixed_point_pi_controller_unit.sv =====
`timescale 1ns / 1ps

// PI controller with a clamped integral accumulator.
// input channel: in_valid / in_stall carry one setpoint and feedback word.
// output channel: out_valid / out_stall carry one drive word per input word.
// config port: cfg_write with cfg_index and cfg_data writes kp (0), ki (1),
// integral_upper (2) and integral_lower (3); other indexes are ignored.
// write config only while no word is in flight.
// order: an accepted word is taken into the input register, and its drive is
// registered into the output register when the word moves on, which waits
// while the output is stalled.
// throughput: one word per cycle while out_stall is low, set by the single
// registered pass through both multipliers, the accumulator and the clamps.
// the integral accumulator is updated as the word leaves the input register.
// reset clears the gains, opens the integral limits fully, clears the
// accumulator and empties both registers.
// when out_stall is high the drive word holds; the input register can still
// take one more word, after which in_stall rises until the output moves.
module fixed_point_pi_controller_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [15:0]                    setpoint,
  input  logic signed [15:0]                    feedback,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [15:0]                    drive,
  input  logic                                  cfg_write,
  input  logic [fppi_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fppi_pkg::CFG_W-1:0]            cfg_data
);
  import fppi_pkg::*;

  cfg_t                      cfg;
  logic signed [INTEG_W-1:0] integral_sum;
  logic signed [INTEG_W-1:0] integral_next;
  logic signed [DATA_W-1:0]  drive_next;
  logic                      s1_valid;
  logic signed [DATA_W-1:0]  s1_setpoint;
  logic signed [DATA_W-1:0]  s1_feedback;
  logic                      advance;
  logic                      move;
  logic                      in_take;

  assign advance  = !out_valid || !out_stall;
  assign move     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  fppi_calc u_calc (
    .cfg           (cfg),
    .setpoint      (s1_setpoint),
    .feedback      (s1_feedback),
    .integral_sum  (integral_sum),
    .integral_next (integral_next),
    .drive_next    (drive_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp             <= '0;
      cfg.ki             <= '0;
      cfg.integral_upper <= INTEG_UPPER_RST;
      cfg.integral_lower <= INTEG_LOWER_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KP:          cfg.kp             <= cfg_data[GAIN_W-1:0];
        REG_KI:          cfg.ki             <= cfg_data[GAIN_W-1:0];
        REG_INTEG_UPPER: cfg.integral_upper <= cfg_data[INTEG_W-1:0];
        REG_INTEG_LOWER: cfg.integral_lower <= cfg_data[INTEG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      integral_sum <= '0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (move) begin
        s1_valid <= 1'b0;
      end
      if (move) begin
        out_valid    <= 1'b1;
        integral_sum <= integral_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_setpoint <= setpoint;
      s1_feedback <= feedback;
    end
    if (move) begin
      drive <= drive_next;
    end
  end

  // input stalls only while the input register holds a word
  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("in_stall raised with empty input register");

  // a word leaving the input register shows up on the output
  a_move_to_out: assert property (@(posedge clk) disable iff (rst)
    move |=> out_valid)
    else $error("word lost between stages");

  // accumulator holds when the integral gain is zero
  a_integ_hold: assert property (@(posedge clk) disable iff (rst)
    (move && cfg.ki == '0) |=> $stable(integral_sum))
    else $error("accumulator changed with ki zero");

  // accumulator stays inside ordered limits after an update
  a_integ_bounds: assert property (@(posedge clk) disable iff (rst)
    (move && cfg.ki != '0 && cfg.integral_lower <= cfg.integral_upper) |=>
      (integral_sum <= $past(cfg.integral_upper) &&
       integral_sum >= $past(cfg.integral_lower)))
    else $error("accumulator outside its limits");

  // accumulator only changes when a word moves
  a_integ_only_on_move: assert property (@(posedge clk) disable iff (rst)
    !move |=> $stable(integral_sum))
    else $error("accumulator changed without a word");

endmodule
